### sv/msb_bit_field_reader_defines.svh
// Assertion macros used by the checker file of this block.
`ifndef MSB_BIT_FIELD_READER_DEFINES_SVH
`define MSB_BIT_FIELD_READER_DEFINES_SVH

// The consequent holds in the same cycle as the antecedent.
`define MBFR_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("msb_bit_field_reader: same-cycle check failed");

// The consequent holds in the cycle after the antecedent.
`define MBFR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("msb_bit_field_reader: next-cycle check failed");

`endif

### sv/mbfr_pkg.sv
package mbfr_pkg;

  localparam int STORE_BYTES = 4096;
  localparam int STORE_AW    = $clog2(STORE_BYTES);
  localparam int CURSOR_W    = 16;
  localparam int SIZE_W      = 13;
  localparam int IN_TDATA_W  = 96;
  localparam int OUT_TDATA_W = 40;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 13'd4096;

  localparam logic [2:0] CMD_LOAD   = 3'd0;
  localparam logic [2:0] CMD_REWIND = 3'd1;
  localparam logic [2:0] CMD_RAW    = 3'd2;
  localparam logic [2:0] CMD_FLAG   = 3'd3;
  localparam logic [2:0] CMD_VARLEN = 3'd4;
  localparam logic [2:0] CMD_RANGED = 3'd5;

  function automatic logic [5:0] width_lookup(input logic [3:0] sel);
    logic [5:0] w;
    if (sel == 4'hF) begin
      w = 6'd32;
    end else begin
      w = {2'b00, sel};
    end
    return w;
  endfunction

  function automatic logic [3:0] byte_bit_length(input logic [7:0] v);
    logic [3:0] b;
    b = 4'd0;
    for (int i = 0; i < 8; i++) begin
      if (v[i]) begin
        b = 4'(i + 1);
      end
    end
    return b;
  endfunction

  function automatic logic [5:0] bit_length(input logic [31:0] v);
    logic [5:0] b;
    if (v[31:24] != 8'd0) begin
      b = 6'd24 + {2'b00, byte_bit_length(v[31:24])};
    end else if (v[23:16] != 8'd0) begin
      b = 6'd16 + {2'b00, byte_bit_length(v[23:16])};
    end else if (v[15:8] != 8'd0) begin
      b = 6'd8 + {2'b00, byte_bit_length(v[15:8])};
    end else begin
      b = {2'b00, byte_bit_length(v[7:0])};
    end
    return b;
  endfunction

endpackage

### sv/msb_bit_field_reader.sv
// MSB-first bit field reader over a 4096-byte store with a 16-bit bit cursor.
// Load-byte and rewind commands finish in the cycle of their transfer and give no
// result. A read of n bits (n above zero) at bit offset o within the current byte
// fetches ceil((o+n)/8) bytes, one per cycle through the single read port of the
// store, and the block takes no new command until the read's result has moved to
// the output register; a zero-bit read or a flag read with the cursor past the data
// size fetches no bytes. A variable-length read runs a flag read, a 4-bit read and
// the magnitude read in turn through the same fetch path. The result waits in an
// output register, and the next command transfers while it waits; a result that
// is ready while the previous one is still held stalls the block until the held
// one is taken.
module msb_bit_field_reader (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // command, byte_address, byte_value, bit_count, range_low, range_high
  input  logic [mbfr_pkg::IN_TDATA_W-1:0]  in_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // result_value, flag_bit, overrun
  output logic [mbfr_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [mbfr_pkg::SIZE_W-1:0]      cfg_data
);
  import mbfr_pkg::*;

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_START   = 3'd1;
  localparam logic [2:0] ST_FETCH   = 3'd2;
  localparam logic [2:0] ST_EXTRACT = 3'd3;
  localparam logic [2:0] ST_DONE    = 3'd4;

  logic [2:0]  in_cmd;
  logic [11:0] in_addr;
  logic [7:0]  in_bval;
  logic [5:0]  in_cnt;
  logic [31:0] in_lo;
  logic [31:0] in_hi;

  assign in_cmd  = in_tdata[2:0];
  assign in_addr = in_tdata[14:3];
  assign in_bval = in_tdata[22:15];
  assign in_cnt  = in_tdata[28:23];
  assign in_lo   = in_tdata[60:29];
  assign in_hi   = in_tdata[92:61];

  logic [2:0]          state_r, state_nxt;
  logic [CURSOR_W-1:0] cur_r, cur_nxt;
  logic [SIZE_W-1:0]   size_r;
  logic [2:0]          cmd_r, cmd_nxt;
  logic [5:0]          cnt_r, cnt_nxt;
  logic [31:0]         lo_r, lo_nxt;
  logic [31:0]         diff_r, diff_nxt;
  logic [1:0]          phase_r, phase_nxt;
  logic                sign_r, sign_nxt;
  logic [3:0]          sel_r, sel_nxt;
  logic                ovr_r, ovr_nxt;
  logic [5:0]          n_r, n_nxt;
  logic [2:0]          off_r, off_nxt;
  logic [2:0]          nbytes_r, nbytes_nxt;
  logic [2:0]          issued_r, issued_nxt;
  logic [2:0]          got_r, got_nxt;
  logic                pend_r;
  logic [13:0]         base_r, base_nxt;
  logic [39:0]         win_r, win_nxt;
  logic [31:0]         res_val_r, res_val_nxt;
  logic                res_flag_r, res_flag_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [31:0]         out_val_r, out_val_nxt;
  logic                out_flag_r, out_flag_nxt;
  logic                out_ovr_r, out_ovr_nxt;

  logic [7:0]          mem [STORE_BYTES];
  logic [7:0]          mem_q_r;
  logic                mem_we;
  logic                mem_re;
  logic [STORE_AW-1:0] mem_raddr;

  logic                in_xfer;
  logic [CURSOR_W-1:0] size_bits;
  logic                is_flag;
  logic [5:0]          n_want;
  logic                flag_past;
  logic [5:0]          n_eff;
  logic [5:0]          span_p7;
  logic [16:0]         end_pos;
  logic [5:0]          span_e;
  logic [2:0]          sh;
  logic [39:0]         win_sh;
  logic [31:0]         mask;
  logic [31:0]         field;

  assign in_tready  = (state_r == ST_IDLE);
  assign in_xfer    = in_tvalid && in_tready;
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_ovr_r, out_flag_r, out_val_r};
  assign size_bits  = {size_r, 3'b000};

  assign mem_we    = in_xfer && (in_cmd == CMD_LOAD);
  assign mem_re    = (state_r == ST_FETCH) && (issued_r != nbytes_r);
  assign mem_raddr = STORE_AW'(base_r + {11'd0, issued_r});

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[STORE_AW'(in_addr)] <= in_bval;
    end
    if (mem_re) begin
      mem_q_r <= mem[mem_raddr];
    end
  end

  // Field length and bounds for the read step about to start.
  always_comb begin
    is_flag = (cmd_r == CMD_FLAG) || ((cmd_r == CMD_VARLEN) && (phase_r == 2'd0));
    case (cmd_r)
      CMD_RAW:    n_want = (cnt_r > 6'd32) ? 6'd32 : cnt_r;
      CMD_FLAG:   n_want = 6'd1;
      CMD_VARLEN: begin
        if (phase_r == 2'd0) begin
          n_want = 6'd1;
        end else if (phase_r == 2'd1) begin
          n_want = 6'd4;
        end else begin
          n_want = width_lookup(sel_r);
        end
      end
      CMD_RANGED: n_want = bit_length(diff_r);
      default:    n_want = 6'd0;
    endcase
    flag_past = is_flag && (cur_r >= size_bits);
    n_eff     = flag_past ? 6'd0 : n_want;
    span_p7   = {3'b000, cur_r[2:0]} + n_eff + 6'd7;
    end_pos   = {1'b0, cur_r} + 17'(n_eff);
  end

  // Field extraction from the fetched bytes.
  always_comb begin
    span_e = {3'b000, off_r} + n_r;
    sh     = 3'(6'd0 - span_e);
    win_sh = win_r >> sh;
    mask   = (n_r >= 6'd32) ? 32'hFFFF_FFFF : ((32'd1 << n_r) - 32'd1);
    field  = win_sh[31:0] & mask;
  end

  always_comb begin
    state_nxt    = state_r;
    cur_nxt      = cur_r;
    cmd_nxt      = cmd_r;
    cnt_nxt      = cnt_r;
    lo_nxt       = lo_r;
    diff_nxt     = diff_r;
    phase_nxt    = phase_r;
    sign_nxt     = sign_r;
    sel_nxt      = sel_r;
    ovr_nxt      = ovr_r;
    n_nxt        = n_r;
    off_nxt      = off_r;
    nbytes_nxt   = nbytes_r;
    issued_nxt   = issued_r;
    got_nxt      = got_r;
    base_nxt     = base_r;
    win_nxt      = win_r;
    res_val_nxt  = res_val_r;
    res_flag_nxt = res_flag_r;
    out_valid_nxt = out_valid_r;
    out_val_nxt  = out_val_r;
    out_flag_nxt = out_flag_r;
    out_ovr_nxt  = out_ovr_r;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          unique case (in_cmd) inside
            CMD_LOAD: begin
            end
            CMD_REWIND: begin
              cur_nxt = '0;
            end
            CMD_RAW, CMD_FLAG, CMD_VARLEN, CMD_RANGED: begin
              cmd_nxt      = in_cmd;
              cnt_nxt      = in_cnt;
              lo_nxt       = in_lo;
              diff_nxt     = in_hi - in_lo;
              phase_nxt    = 2'd0;
              ovr_nxt      = 1'b0;
              res_val_nxt  = '0;
              res_flag_nxt = 1'b0;
              state_nxt    = ST_START;
            end
            default: begin
            end
          endcase
        end
      end
      ST_START: begin
        n_nxt      = n_eff;
        off_nxt    = cur_r[2:0];
        nbytes_nxt = span_p7[5:3];
        base_nxt   = {1'b0, cur_r[CURSOR_W-1:3]};
        issued_nxt = '0;
        got_nxt    = '0;
        win_nxt    = '0;
        if (flag_past || ((n_eff != 6'd0) && (end_pos > {1'b0, size_bits}))) begin
          ovr_nxt = 1'b1;
        end
        state_nxt = (n_eff == 6'd0) ? ST_EXTRACT : ST_FETCH;
      end
      ST_FETCH: begin
        if (mem_re) begin
          issued_nxt = issued_r + 3'd1;
        end
        if (pend_r) begin
          win_nxt = {win_r[31:0], mem_q_r};
          got_nxt = got_r + 3'd1;
          if ((got_r + 3'd1) == nbytes_r) begin
            state_nxt = ST_EXTRACT;
          end
        end
      end
      ST_EXTRACT: begin
        cur_nxt   = cur_r + CURSOR_W'(n_r);
        state_nxt = ST_DONE;
        case (cmd_r)
          CMD_RAW:    res_val_nxt = field;
          CMD_FLAG:   res_flag_nxt = field[0];
          CMD_VARLEN: begin
            if (phase_r == 2'd0) begin
              sign_nxt  = field[0];
              phase_nxt = 2'd1;
              state_nxt = ST_START;
            end else if (phase_r == 2'd1) begin
              sel_nxt   = field[3:0];
              phase_nxt = 2'd2;
              state_nxt = ST_START;
            end else begin
              res_val_nxt = sign_r ? (32'd0 - field) : field;
            end
          end
          CMD_RANGED: res_val_nxt = field + lo_r;
          default:    res_val_nxt = '0;
        endcase
      end
      ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_val_nxt   = res_val_r;
          out_flag_nxt  = res_flag_r;
          out_ovr_nxt   = ovr_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cur_r       <= '0;
      size_r      <= SIZE_RESET;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cur_r       <= cur_nxt;
      pend_r      <= mem_re;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        size_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    cnt_r      <= cnt_nxt;
    lo_r       <= lo_nxt;
    diff_r     <= diff_nxt;
    phase_r    <= phase_nxt;
    sign_r     <= sign_nxt;
    sel_r      <= sel_nxt;
    ovr_r      <= ovr_nxt;
    n_r        <= n_nxt;
    off_r      <= off_nxt;
    nbytes_r   <= nbytes_nxt;
    issued_r   <= issued_nxt;
    got_r      <= got_nxt;
    base_r     <= base_nxt;
    win_r      <= win_nxt;
    res_val_r  <= res_val_nxt;
    res_flag_r <= res_flag_nxt;
    out_val_r  <= out_val_nxt;
    out_flag_r <= out_flag_nxt;
    out_ovr_r  <= out_ovr_nxt;
  end

endmodule

### sv/mbfr_checker.sv
`include "msb_bit_field_reader_defines.svh"

module mbfr_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic [mbfr_pkg::IN_TDATA_W-1:0]  in_tdata,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [mbfr_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic                            cfg_valid,
  input logic                            cfg_ready,
  input logic [mbfr_pkg::SIZE_W-1:0]      cfg_data
);
  import mbfr_pkg::*;

  logic in_xfer;
  logic read_cmd;

  assign in_xfer  = in_tvalid && in_tready;
  assign read_cmd = (in_tdata[2:0] == CMD_RAW) || (in_tdata[2:0] == CMD_FLAG) ||
                    (in_tdata[2:0] == CMD_VARLEN) || (in_tdata[2:0] == CMD_RANGED);

  `MBFR_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
  `MBFR_ASSERT_NEXT(a_read_busy, in_xfer && read_cmd, !in_tready)
  `MBFR_ASSERT_NEXT(a_nonread_free, in_xfer && !read_cmd, in_tready && !$rose(out_tvalid))
  `MBFR_ASSERT_SAME(a_ready_drop, $fell(in_tready), $past(in_xfer))
  `MBFR_ASSERT_SAME(a_cfg_taken, cfg_valid, cfg_ready)

endmodule

bind msb_bit_field_reader mbfr_checker u_mbfr_checker (.*);

### tb/tb_msb_bit_field_reader.sv
module tb_msb_bit_field_reader;
  timeunit 1ns;
  timeprecision 1ps;

  import mbfr_pkg::*;

  // Mirrors the byte store and bit cursor and holds the reads still owed by the block.
  class bit_field_tracker;
    logic [7:0]  mirror_store [STORE_BYTES];
    bit          mirror_written [STORE_BYTES];
    logic [15:0] mirror_cursor;
    logic [12:0] mirror_size;
    bit          read_overran;
    logic [33:0] expected_reads [$];
    int unsigned fail_count;

    function new();
      mirror_cursor = '0;
      mirror_size = SIZE_RESET;
      fail_count = 0;
    endfunction

    task report(string msg);
      $display("ERROR: %s", msg);
      fail_count++;
    endtask

    function int unsigned width_of(logic [31:0] v);
      int unsigned b;
      b = 0;
      while (v != 0) begin
        b++;
        v = v >> 1;
      end
      return b;
    endfunction

    function logic [31:0] take_bits(int unsigned n);
      logic [31:0] acc;
      int unsigned pos;
      acc = '0;
      if (n == 0) return '0;
      if (n > 32) n = 32;
      if (32'(mirror_cursor) + n > 32'(mirror_size) * 8) read_overran = 1'b1;
      for (int unsigned i = 0; i < n; i++) begin
        pos = 32'(mirror_cursor) + i;
        acc = {acc[30:0], mirror_store[12'((pos >> 3) % STORE_BYTES)][~pos[2:0]]};
      end
      mirror_cursor = mirror_cursor + 16'(n);
      return acc;
    endfunction

    function logic take_flag();
      int unsigned pos;
      logic b;
      pos = 32'(mirror_cursor);
      if (pos >= 32'(mirror_size) * 8) begin
        read_overran = 1'b1;
        return 1'b0;
      end
      b = mirror_store[12'((pos >> 3) % STORE_BYTES)][~pos[2:0]];
      mirror_cursor = mirror_cursor + 16'd1;
      return b;
    endfunction

    function void set_size(logic [12:0] v);
      mirror_size = v;
    endfunction

    function void note_command(logic [95:0] word);
      logic [2:0]  cmd;
      logic [11:0] addr;
      logic [7:0]  val;
      logic [5:0]  cnt;
      logic [31:0] lo, hi, value, mag;
      logic        flag, neg;
      logic [3:0]  sel;
      cmd = word[2:0];
      addr = word[14:3];
      val = word[22:15];
      cnt = word[28:23];
      lo = word[60:29];
      hi = word[92:61];
      value = '0;
      flag = 1'b0;
      read_overran = 1'b0;
      case (cmd)
        CMD_LOAD: begin
          mirror_store[addr] = val;
          mirror_written[addr] = 1'b1;
          return;
        end
        CMD_REWIND: begin
          mirror_cursor = '0;
          return;
        end
        CMD_RAW: value = take_bits(cnt);
        CMD_FLAG: flag = take_flag();
        CMD_VARLEN: begin
          neg = take_flag();
          sel = 4'(take_bits(4));
          mag = take_bits((sel == 4'hF) ? 32 : sel);
          value = neg ? (32'd0 - mag) : mag;
        end
        CMD_RANGED: value = take_bits(width_of(hi - lo)) + lo;
        default: return;
      endcase
      expected_reads.push_back({read_overran, flag, value});
    endfunction

    task check_result(logic [39:0] word);
      logic [33:0] want;
      if (expected_reads.size() == 0) begin
        report($sformatf("unexpected result transfer %h", word));
        return;
      end
      want = expected_reads.pop_front();
      if (word[31:0] !== want[31:0]) begin
        report($sformatf("result_value got %h, want %h", word[31:0], want[31:0]));
      end
      if (word[32] !== want[32]) begin
        report($sformatf("flag_bit got %b, want %b", word[32], want[32]));
      end
      if (word[33] !== want[33]) begin
        report($sformatf("overrun got %b, want %b", word[33], want[33]));
      end
    endtask
  endclass

  localparam logic [2:0] CMD_SPARE_A = 3'd6;
  localparam logic [2:0] CMD_SPARE_B = 3'd7;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  // command, byte_address, byte_value, bit_count, range_low, range_high, zero fill
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   out_tvalid;
  logic                   out_tready;
  // result_value, flag_bit, overrun, zero fill
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [SIZE_W-1:0]      cfg_data;

  bit no_idle = 1'b0;
  bit_field_tracker tracker;

  msb_bit_field_reader i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      out_tready = no_idle || ($urandom_range(0, 99) >= 21);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      tracker.check_result(out_tdata);
    end
  end

  task automatic send_word(input logic [95:0] word);
    while (!no_idle && $urandom_range(0, 99) < 21) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata = word;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    tracker.note_command(word);
    @(negedge clk);
  endtask

  // Reads are preceded by loads of any unwritten byte they could touch.
  task automatic issue(input logic [2:0] cmd, input logic [11:0] addr, input logic [7:0] val,
                       input logic [5:0] cnt, input logic [31:0] lo, input logic [31:0] hi);
    logic [11:0] idx;
    if (cmd inside {CMD_RAW, CMD_FLAG, CMD_VARLEN, CMD_RANGED}) begin
      for (int k = 0; k < 6; k++) begin
        idx = 12'(((32'(tracker.mirror_cursor) >> 3) + k) % STORE_BYTES);
        if (!tracker.mirror_written[idx]) begin
          send_word({3'b000, 64'd0, 6'd0, 8'($urandom_range(0, 255)), idx, CMD_LOAD});
        end
      end
    end
    send_word({3'b000, hi, lo, cnt, val, addr, cmd});
  endtask

  task automatic settle();
    in_tvalid = 1'b0;
    while (tracker.expected_reads.size() != 0) @(posedge clk);
    repeat (32) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_size(input logic [SIZE_W-1:0] v);
    cfg_valid = 1'b1;
    cfg_data = v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    tracker.set_size(v);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic random_item();
    logic [2:0]  cmd;
    logic [5:0]  cnt;
    logic [31:0] lo, hi;
    logic [31:0] corner_words [4];
    int unsigned pick;
    corner_words = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF};
    pick = $urandom_range(0, 99);
    if (pick < 30) cmd = CMD_RAW;
    else if (pick < 45) cmd = CMD_FLAG;
    else if (pick < 65) cmd = CMD_VARLEN;
    else if (pick < 85) cmd = CMD_RANGED;
    else if (pick < 92) cmd = CMD_LOAD;
    else if (pick < 97) cmd = CMD_REWIND;
    else if (pick < 98) cmd = CMD_SPARE_A;
    else cmd = CMD_SPARE_B;
    cnt = ($urandom_range(0, 3) != 0) ? 6'($urandom_range(0, 32)) : 6'($urandom_range(0, 63));
    lo = $urandom();
    case ($urandom_range(0, 3))
      0: hi = lo + $urandom_range(0, 300);
      1: hi = $urandom();
      2: begin
        lo = corner_words[2'($urandom_range(0, 3))];
        hi = corner_words[2'($urandom_range(0, 3))];
      end
      default: hi = lo + (32'd1 << $urandom_range(0, 31));
    endcase
    issue(cmd, 12'($urandom()), 8'($urandom()), cnt, lo, hi);
  endtask

  initial begin
    logic [SIZE_W-1:0] phase_sizes [6];

    tracker = new();
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    write_size(SIZE_RESET);
    // Sign set and width index fifteen at the start of the store.
    issue(CMD_LOAD, 12'd0, 8'hFB, 6'd0, 32'd0, 32'd0);
    issue(CMD_LOAD, 12'd1, 8'h00, 6'd0, 32'd0, 32'd0);
    issue(CMD_LOAD, 12'hFFF, 8'hFF, 6'd0, 32'd0, 32'd0);
    issue(CMD_VARLEN, 12'd0, 8'd0, 6'd0, 32'd0, 32'd0);
    issue(CMD_REWIND, 12'd0, 8'd0, 6'd0, 32'd0, 32'd0);
    issue(CMD_RAW, 12'd0, 8'd0, 6'd0, 32'd0, 32'd0);
    issue(CMD_RAW, 12'd0, 8'd0, 6'd63, 32'd0, 32'd0);
    issue(CMD_RAW, 12'd0, 8'd0, 6'd1, 32'd0, 32'd0);
    issue(CMD_FLAG, 12'd0, 8'd0, 6'd0, 32'd0, 32'd0);
    issue(CMD_RANGED, 12'd0, 8'd0, 6'd0, 32'h8000_0000, 32'h7FFF_FFFF);
    issue(CMD_RANGED, 12'd0, 8'd0, 6'd0, 32'hFFFF_FFFB, 32'hFFFF_FFFB);
    issue(CMD_RANGED, 12'd0, 8'd0, 6'd0, 32'd1, 32'd0);
    issue(CMD_SPARE_A, 12'hFFF, 8'hFF, 6'd63, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    issue(CMD_SPARE_B, 12'd0, 8'd0, 6'd0, 32'd0, 32'd0);
    issue(CMD_RAW, 12'd0, 8'd0, 6'd32, 32'd0, 32'd0);
    issue(CMD_VARLEN, 12'd0, 8'd0, 6'd0, 32'd0, 32'd0);
    settle();
    write_size(13'd1);
    issue(CMD_REWIND, 12'd0, 8'd0, 6'd0, 32'd0, 32'd0);
    issue(CMD_RAW, 12'd0, 8'd0, 6'd8, 32'd0, 32'd0);
    issue(CMD_FLAG, 12'd0, 8'd0, 6'd0, 32'd0, 32'd0);
    issue(CMD_RAW, 12'd0, 8'd0, 6'd3, 32'd0, 32'd0);
    issue(CMD_VARLEN, 12'd0, 8'd0, 6'd0, 32'd0, 32'd0);

    phase_sizes = '{13'd0, 13'd1, 13'd16, 13'($urandom_range(2, 700)), 13'd4095, SIZE_RESET};
    for (int p = 0; p < 6; p++) begin
      settle();
      write_size(phase_sizes[3'(p)]);
      no_idle = (p == 3);
      repeat (65) random_item();
    end
    no_idle = 1'b0;

    settle();
    if (tracker.fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule

### filelist.f
+incdir+sv
sv/mbfr_pkg.sv
sv/msb_bit_field_reader.sv
sv/mbfr_checker.sv
tb/tb_msb_bit_field_reader.sv
